// ===== rtl/core/llp_pkg.sv =====
// Shared constants, result codes and queue item type for the LL(1) parser.
package llp_pkg;

    localparam int MAX_RHS     = 4;
    localparam int STACK_DEPTH = 64;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = STACK_AW + 1;
    localparam int RHS_CAP     = (MAX_RHS < 4) ? MAX_RHS : 4;
    localparam int SYM_W       = 7;
    localparam int LEN_W       = 3;
    localparam int SYMS_W      = 28;
    localparam int K_W         = 2;
    localparam int ROW_W       = 5;
    localparam int LIM_W       = 6;
    localparam int NT_ROWS     = 26;
    localparam int TERM_COLS   = 128;
    localparam int TBL_DEPTH   = NT_ROWS * TERM_COLS;
    localparam int TBL_AW      = $clog2(TBL_DEPTH);
    localparam int ENT_W       = 1 + LEN_W + SYMS_W;

    localparam logic [SYM_W-1:0] END_MARK    = 7'd36;
    localparam logic [SYM_W-1:0] NT_FIRST    = 7'd65;
    localparam logic [SYM_W-1:0] NT_LAST     = 7'd90;
    localparam logic [SYM_W-1:0] START_RESET = 7'd69;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 6'd63;
    localparam logic [ROW_W-1:0] ROW_LAST    = 5'd25;

    localparam logic [2:0] KIND_EXPAND   = 3'd0;
    localparam logic [2:0] KIND_MATCH    = 3'd1;
    localparam logic [2:0] KIND_ACCEPT   = 3'd2;
    localparam logic [2:0] KIND_MISMATCH = 3'd3;
    localparam logic [2:0] KIND_NOENTRY  = 3'd4;
    localparam logic [2:0] KIND_OVERFLOW = 3'd5;
    localparam logic [2:0] KIND_LIMIT    = 3'd6;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic              is_tok;
        logic              keep;
        logic [SYM_W-1:0]  col;
        logic              is_end;
        logic [ROW_W-1:0]  row;
        logic              ent_valid;
        logic [LEN_W-1:0]  len;
        logic [SYMS_W-1:0] syms;
    } t_item;

endpackage

// ===== rtl/core/ll1_predictive_parser_unit.sv =====
// A new parse first runs INIT0 and INIT1; each stack step runs RD and EVAL, and an expansion adds
// TBL and one PUSH per pushed symbol. Loads write the table as they leave the queue, and results
// wait in the result register. New items are taken only in IDLE; the two-entry queue buffers beats.
// Reset is synchronous, active low; after reset the parse table is swept to invalid,
// during which no input beat is accepted (configuration writes are taken).
module ll1_predictive_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [6:0]  i_lookahead,
    input  logic        i_is_end,
    input  logic [4:0]  i_load_nonterminal,
    input  logic        i_entry_valid,
    input  logic [2:0]  i_rhs_length,
    input  logic [27:0] i_rhs_symbols,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [6:0]  o_nonterminal,
    output logic [2:0]  o_used_rhs_length,
    output logic [27:0] o_used_rhs_symbols,
    output logic [6:0]  o_matched_symbol,
    output logic        o_last
);
    logic [6:0]     r_start;
    logic [5:0]     r_limit;
    logic           q_valid;
    llp_pkg::t_item q_item;
    logic           q_pop;
    logic           clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= llp_pkg::START_RESET;
            r_limit <= llp_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                llp_pkg::CFG_START: r_start <= i_cfg_data;
                llp_pkg::CFG_LIMIT: r_limit <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    llp_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (!clearing),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_lookahead        (i_lookahead),
        .i_is_end           (i_is_end),
        .i_load_nonterminal (i_load_nonterminal),
        .i_entry_valid      (i_entry_valid),
        .i_rhs_length       (i_rhs_length),
        .i_rhs_symbols      (i_rhs_symbols),
        .o_q_valid          (q_valid),
        .o_q_item           (q_item),
        .i_q_pop            (q_pop)
    );

    llp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (r_start),
        .i_limit            (r_limit),
        .i_q_valid          (q_valid),
        .i_q_item           (q_item),
        .o_q_pop            (q_pop),
        .o_clearing         (clearing),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_kind             (o_kind),
        .o_nonterminal      (o_nonterminal),
        .o_used_rhs_length  (o_used_rhs_length),
        .o_used_rhs_symbols (o_used_rhs_symbols),
        .o_matched_symbol   (o_matched_symbol),
        .o_last             (o_last)
    );
endmodule

// ===== rtl/core/llp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module llp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/llp_front.sv =====
// Front end: accept input beats, classify them and queue them for the sequencer.
module llp_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [6:0]                  i_lookahead,
    input  logic                        i_is_end,
    input  logic [4:0]                  i_load_nonterminal,
    input  logic                        i_entry_valid,
    input  logic [2:0]                  i_rhs_length,
    input  logic [27:0]                 i_rhs_symbols,
    output logic                        o_q_valid,
    output llp_pkg::t_item              o_q_item,
    input  logic                        i_q_pop
);
    llp_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    llp_pkg::t_item w_item;
    logic           w_push;

    always_comb begin
        w_item.is_tok    = i_mode;
        w_item.keep      = i_mode | (i_load_nonterminal <= llp_pkg::ROW_LAST);
        w_item.col       = (i_mode & i_is_end) ? llp_pkg::END_MARK : i_lookahead;
        w_item.is_end    = i_is_end;
        w_item.row       = i_load_nonterminal;
        w_item.ent_valid = i_entry_valid;
        // saturate overlong right-hand sides
        w_item.len       = (i_rhs_length > llp_pkg::LEN_W'(llp_pkg::RHS_CAP)) ?
                           llp_pkg::LEN_W'(llp_pkg::RHS_CAP) : i_rhs_length;
        w_item.syms      = i_rhs_symbols;
    end

    assign o_in_ready = i_en && (r_cnt != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule

// ===== rtl/core/llp_back.sv =====
// Back end: table clear, table loads, stack sequencer and the result register.
module llp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [6:0]                  i_start,
    input  logic [5:0]                  i_limit,
    input  logic                        i_q_valid,
    input  llp_pkg::t_item              i_q_item,
    output logic                        o_q_pop,
    output logic                        o_clearing,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [2:0]                  o_kind,
    output logic [6:0]                  o_nonterminal,
    output logic [2:0]                  o_used_rhs_length,
    output logic [27:0]                 o_used_rhs_symbols,
    output logic [6:0]                  o_matched_symbol,
    output logic                        o_last
);
    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INIT0 = 3'd2;
    localparam logic [2:0] S_INIT1 = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_EVAL  = 3'd5;
    localparam logic [2:0] S_TBL   = 3'd6;
    localparam logic [2:0] S_PUSH  = 3'd7;

    localparam int CW = llp_pkg::CNT_W;
    localparam int AW = llp_pkg::STACK_AW;

    logic [2:0]                      r_state, n_state;
    logic [llp_pkg::TBL_AW-1:0]      r_clr;
    logic [CW-1:0]                   r_count, n_count;
    logic                            r_active, n_active;
    logic                            r_empty, n_empty;
    logic [llp_pkg::SYM_W-1:0]       r_tok, n_tok;
    logic                            r_is_end, n_is_end;
    logic [llp_pkg::SYM_W-1:0]       r_top, n_top;
    logic [llp_pkg::LIM_W-1:0]       r_exp, n_exp;
    logic [llp_pkg::LEN_W-1:0]       r_len, n_len;
    logic [llp_pkg::SYMS_W-1:0]      r_syms, n_syms;
    logic [llp_pkg::K_W-1:0]         r_k, n_k;

    logic                            r_ov;
    logic [2:0]                      r_kind;
    logic [6:0]                      r_nt;
    logic [2:0]                      r_olen;
    logic [27:0]                     r_osyms;
    logic [6:0]                      r_match;
    logic                            r_last;

    logic                            w_emit;
    logic [2:0]                      w_kind;
    logic [2:0]                      w_olen;
    logic [27:0]                     w_osyms;
    logic [6:0]                      w_match;
    logic                            w_last;
    logic                            w_free;

    logic                            tbl_we, tbl_re;
    logic [llp_pkg::TBL_AW-1:0]      tbl_waddr, tbl_raddr;
    logic [llp_pkg::ENT_W-1:0]       tbl_wdata, tbl_rdata;
    logic                            stk_we, stk_re;
    logic [AW-1:0]                   stk_waddr, stk_raddr;
    logic [llp_pkg::SYM_W-1:0]       stk_wdata, stk_rdata;

    logic [llp_pkg::SYM_W-1:0]       w_top;
    logic [CW-1:0]                   w_base;
    logic [CW:0]                     w_fill;
    logic [CW:0]                     w_paddr;
    logic [llp_pkg::SYM_W-1:0]       w_nt_off;

    llp_ram #(.WIDTH(llp_pkg::ENT_W), .DEPTH(llp_pkg::TBL_DEPTH)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    llp_ram #(.WIDTH(llp_pkg::SYM_W), .DEPTH(llp_pkg::STACK_DEPTH)) u_stk (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign w_free     = !r_ov || i_out_ready;
    assign o_clearing = (r_state == S_CLR);
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign w_top      = r_empty ? llp_pkg::END_MARK : stk_rdata;
    assign w_base     = r_count - CW'(1);
    assign w_fill     = {1'b0, w_base} + (CW+1)'(tbl_rdata[30:28]);
    assign w_paddr    = {1'b0, w_base} + (CW+1)'(r_len) - (CW+1)'(1) - (CW+1)'(r_k);
    assign w_nt_off   = w_top - llp_pkg::NT_FIRST;

    // table port: clear sweep or load writes, lookup reads from EVAL
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_clr;
        tbl_wdata = '0;
        if (r_state == S_CLR) begin
            tbl_we = 1'b1;
        end else if (o_q_pop && !i_q_item.is_tok && i_q_item.keep) begin
            tbl_we    = 1'b1;
            tbl_waddr = {i_q_item.row, i_q_item.col};
            tbl_wdata = i_q_item.ent_valid ? {1'b1, i_q_item.len, i_q_item.syms} : '0;
        end
        tbl_raddr = {w_nt_off[llp_pkg::ROW_W-1:0], r_tok};
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_active = r_active;
        n_empty  = r_empty;
        n_tok    = r_tok;
        n_is_end = r_is_end;
        n_top    = r_top;
        n_exp    = r_exp;
        n_len    = r_len;
        n_syms   = r_syms;
        n_k      = r_k;
        w_emit   = 1'b0;
        w_kind   = llp_pkg::KIND_EXPAND;
        w_olen   = '0;
        w_osyms  = '0;
        w_match  = '0;
        w_last   = 1'b1;
        tbl_re   = 1'b0;
        stk_re   = 1'b0;
        stk_raddr = w_base[AW-1:0];
        stk_we   = 1'b0;
        stk_waddr = w_paddr[AW-1:0];
        stk_wdata = r_syms[r_k*llp_pkg::SYM_W +: llp_pkg::SYM_W];
        unique case (r_state)
            S_CLR: begin
                if (r_clr == llp_pkg::TBL_AW'(llp_pkg::TBL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid && i_q_item.is_tok) begin
                    n_tok    = i_q_item.col;
                    n_is_end = i_q_item.is_end;
                    n_exp    = '0;
                    n_state  = r_active ? S_RD : S_INIT0;
                end
            end
            S_INIT0: begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = llp_pkg::END_MARK;
                n_state   = S_INIT1;
            end
            S_INIT1: begin
                stk_we    = 1'b1;
                stk_waddr = AW'(1);
                stk_wdata = i_start;
                n_count   = CW'(2);
                n_active  = 1'b1;
                n_state   = S_RD;
            end
            S_RD: begin
                stk_re  = (r_count != '0);
                n_empty = (r_count == '0);
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_top == llp_pkg::END_MARK) begin
                    if (w_free) begin
                        w_emit   = 1'b1;
                        w_kind   = r_is_end ? llp_pkg::KIND_ACCEPT : llp_pkg::KIND_MISMATCH;
                        n_active = 1'b0;
                        n_state  = S_IDLE;
                    end
                end else if (w_top < llp_pkg::NT_FIRST || w_top > llp_pkg::NT_LAST) begin
                    if (w_free) begin
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                        if (w_top == r_tok) begin
                            w_kind  = llp_pkg::KIND_MATCH;
                            w_match = r_tok;
                            n_count = w_base;
                        end else begin
                            w_kind   = llp_pkg::KIND_MISMATCH;
                            n_active = 1'b0;
                        end
                    end
                end else begin
                    tbl_re  = 1'b1;
                    n_top   = w_top;
                    n_state = S_TBL;
                end
            end
            S_TBL: begin
                if (w_free) begin
                    w_emit = 1'b1;
                    if (!tbl_rdata[31]) begin
                        w_kind   = llp_pkg::KIND_NOENTRY;
                        n_active = 1'b0;
                        n_state  = S_IDLE;
                    end else if (r_exp >= i_limit) begin
                        w_kind   = llp_pkg::KIND_LIMIT;
                        n_active = 1'b0;
                        n_state  = S_IDLE;
                    end else if (w_fill > (CW+1)'(llp_pkg::STACK_DEPTH)) begin
                        w_kind   = llp_pkg::KIND_OVERFLOW;
                        n_active = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        w_kind  = llp_pkg::KIND_EXPAND;
                        w_olen  = tbl_rdata[30:28];
                        w_osyms = tbl_rdata[27:0];
                        w_last  = 1'b0;
                        n_len   = tbl_rdata[30:28];
                        n_syms  = tbl_rdata[27:0];
                        n_k     = '0;
                        n_exp   = r_exp + llp_pkg::LIM_W'(1);
                        if (tbl_rdata[30:28] == '0) begin
                            n_count = w_base;
                            n_state = S_RD;
                        end else begin
                            n_state = S_PUSH;
                        end
                    end
                end
            end
            S_PUSH: begin
                // first symbol lands on top: the top slot is written first
                stk_we = 1'b1;
                n_k    = r_k + llp_pkg::K_W'(1);
                if ((llp_pkg::LEN_W)'(r_k) == r_len - llp_pkg::LEN_W'(1)) begin
                    n_count = w_base + CW'(r_len);
                    n_state = S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_count  <= '0;
            r_active <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_active <= n_active;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + llp_pkg::TBL_AW'(1);
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_empty  <= n_empty;
        r_tok    <= n_tok;
        r_is_end <= n_is_end;
        r_top    <= n_top;
        r_exp    <= n_exp;
        r_len    <= n_len;
        r_syms   <= n_syms;
        r_k      <= n_k;
        if (w_emit) begin
            r_kind  <= w_kind;
            r_nt    <= (r_state == S_TBL) ? r_top : w_top;
            r_olen  <= w_olen;
            r_osyms <= w_osyms;
            r_match <= w_match;
            r_last  <= w_last;
        end
    end

    assign o_out_valid        = r_ov;
    assign o_kind             = r_kind;
    assign o_nonterminal      = r_nt;
    assign o_used_rhs_length  = r_olen;
    assign o_used_rhs_symbols = r_osyms;
    assign o_matched_symbol   = r_match;
    assign o_last             = r_last;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_q_pop)
        else $error("queue popped during table clear");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(llp_pkg::STACK_DEPTH))
        else $error("stack count above depth");
    a_push_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> (llp_pkg::LEN_W'(r_k) < r_len))
        else $error("push index beyond right-hand side");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |-> !w_emit)
        else $error("result overwritten while held");
endmodule

// ===== sim/ll1_predictive_parser_unit_test.sv =====
// Self-checking testbench for the LL(1) predictive parser unit.
module ll1_predictive_parser_unit_test;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [6:0] CH_E = 7'h45;
    localparam logic [6:0] CH_T = 7'h54;
    localparam logic [6:0] CH_X = 7'h58;
    localparam logic [6:0] CH_A = 7'h61;
    localparam logic [6:0] CH_O = 7'h6F;
    localparam logic [6:0] CH_PLUS = 7'h2B;
    localparam logic [6:0] CH_LP = 7'h28;
    localparam logic [6:0] CH_RP = 7'h29;
    localparam logic [4:0] ROW_E = 5'd4;
    localparam logic [4:0] ROW_T = 5'd19;
    localparam logic [4:0] ROW_X = 5'd23;
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TOKEN = 1'b1;

    typedef struct {
        logic        mode;
        logic [6:0]  look;
        logic        is_end;
        logic [4:0]  row;
        logic        ent_valid;
        logic [2:0]  len;
        logic [27:0] syms;
    } t_beat;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  top;
        logic [2:0]  len;
        logic [27:0] syms;
        logic [6:0]  matched;
        logic        last;
    } t_parse_step;

    class parse_scoreboard;
        logic [31:0] rules[llp_pkg::TBL_DEPTH];
        logic [6:0]  sym_stack[llp_pkg::STACK_DEPTH];
        int          depth;
        bit          active;
        logic [6:0]  start_sym;
        logic [5:0]  exp_limit;
        t_parse_step pending[$];
        int          errors;

        function void clear();
            foreach (rules[i]) rules[i] = '0;
            depth = 0;
            active = 0;
            start_sym = llp_pkg::START_RESET;
            exp_limit = llp_pkg::LIMIT_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [6:0] data);
            if (idx == llp_pkg::CFG_START) start_sym = data;
            else exp_limit = data[5:0];
        endfunction

        function void push_step(logic [2:0] k, logic [6:0] top, logic [2:0] len,
                                logic [27:0] syms, logic [6:0] m, logic last);
            t_parse_step s;
            s.kind = k; s.top = top; s.len = len; s.syms = syms;
            s.matched = m; s.last = last;
            pending = {pending, s};
        endfunction

        function void note_input(t_beat b);
            logic [6:0]  tok, top;
            logic [31:0] ent;
            logic [2:0]  len;
            int          n_exp, base;
            if (b.mode == MODE_LOAD) begin
                if (b.row > llp_pkg::ROW_LAST) return;
                len = (b.len > llp_pkg::RHS_CAP) ? 3'(llp_pkg::RHS_CAP) : b.len;
                rules[b.row * llp_pkg::TERM_COLS + b.look] =
                    b.ent_valid ? {1'b1, len, b.syms} : 32'd0;
                return;
            end
            if (!active) begin
                sym_stack[0] = llp_pkg::END_MARK;
                sym_stack[1] = start_sym;
                depth = 2;
                active = 1;
            end
            tok = b.is_end ? llp_pkg::END_MARK : b.look;
            n_exp = 0;
            forever begin
                top = (depth > 0) ? sym_stack[depth-1] : llp_pkg::END_MARK;
                if (top == llp_pkg::END_MARK) begin
                    push_step(b.is_end ? llp_pkg::KIND_ACCEPT : llp_pkg::KIND_MISMATCH,
                              top, 0, 0, 0, 1);
                    active = 0;
                    return;
                end
                if (top < llp_pkg::NT_FIRST || top > llp_pkg::NT_LAST) begin
                    if (top == tok) begin
                        depth--;
                        push_step(llp_pkg::KIND_MATCH, top, 0, 0, tok, 1);
                    end else begin
                        push_step(llp_pkg::KIND_MISMATCH, top, 0, 0, 0, 1);
                        active = 0;
                    end
                    return;
                end
                ent = rules[(top - llp_pkg::NT_FIRST) * llp_pkg::TERM_COLS + tok];
                if (!ent[31]) begin
                    push_step(llp_pkg::KIND_NOENTRY, top, 0, 0, 0, 1);
                    active = 0;
                    return;
                end
                if (n_exp >= exp_limit) begin
                    push_step(llp_pkg::KIND_LIMIT, top, 0, 0, 0, 1);
                    active = 0;
                    return;
                end
                len = ent[30:28];
                base = depth - 1;
                if (base + len > llp_pkg::STACK_DEPTH) begin
                    push_step(llp_pkg::KIND_OVERFLOW, top, 0, 0, 0, 1);
                    active = 0;
                    return;
                end
                // first symbol of the right-hand side ends up on top
                for (int k = 0; k < len; k++)
                    sym_stack[base + len - 1 - k] = ent[7*k +: 7];
                depth = base + len;
                n_exp++;
                push_step(llp_pkg::KIND_EXPAND, top, len, ent[27:0], 0, 0);
            end
        endfunction

        function void check_result(t_parse_step got);
            t_parse_step want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result kind=%0d top=%0d", got.kind, got.top);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display({"result mismatch: exp k=%0d nt=%0d len=%0d syms=%h m=%0d ",
                              "last=%0d / got k=%0d nt=%0d len=%0d syms=%h m=%0d last=%0d"},
                             want.kind, want.top, want.len, want.syms, want.matched,
                             want.last, got.kind, got.top, got.len, got.syms,
                             got.matched, got.last);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_cfg_we, i_cfg_idx;
    logic [6:0]  i_cfg_data;
    logic        i_in_valid, o_in_ready;
    logic        i_mode, i_is_end, i_entry_valid;
    logic [6:0]  i_lookahead;
    logic [4:0]  i_load_nonterminal;
    logic [2:0]  i_rhs_length;
    logic [27:0] i_rhs_symbols;
    logic        o_out_valid, i_out_ready;
    logic [2:0]  o_kind, o_used_rhs_length;
    logic [6:0]  o_nonterminal, o_matched_symbol;
    logic [27:0] o_used_rhs_symbols;
    logic        o_last;

    ll1_predictive_parser_unit dut (.*);

    parse_scoreboard sb = new();
    bit idle_en = 1;
    bit hold_req = 0;
    int hold_cnt = 0;
    int stall_cnt = 0;
    int cycles = 0;
    logic [6:0] sentence[$];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ll1_predictive_parser_unit_test: errors");
            $finish;
        end
    end

    // result side: long hold on request, else random stall bursts
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            i_out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_cnt = $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_parse_step got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.kind = o_kind; got.top = o_nonterminal;
            got.len = o_used_rhs_length; got.syms = o_used_rhs_symbols;
            got.matched = o_matched_symbol; got.last = o_last;
            sb.check_result(got);
        end
    end

    function automatic logic [27:0] pack4(logic [6:0] s0, logic [6:0] s1,
                                          logic [6:0] s2, logic [6:0] s3);
        return {s3, s2, s1, s0};
    endfunction

    task automatic send_beat(t_beat b);
        i_in_valid <= 1'b1;
        i_mode <= b.mode;
        i_lookahead <= b.look;
        i_is_end <= b.is_end;
        i_load_nonterminal <= b.row;
        i_entry_valid <= b.ent_valid;
        i_rhs_length <= b.len;
        i_rhs_symbols <= b.syms;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(b);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic load_rule(logic [4:0] row, logic [6:0] col, logic ev,
                             logic [2:0] len, logic [27:0] syms);
        t_beat b;
        b.mode = MODE_LOAD; b.look = col; b.is_end = 1'($urandom);
        b.row = row; b.ent_valid = ev; b.len = len; b.syms = syms;
        send_beat(b);
    endtask

    task automatic send_token(logic [6:0] ch, logic is_end);
        t_beat b;
        b.mode = MODE_TOKEN; b.look = ch; b.is_end = is_end;
        b.row = 5'($urandom); b.ent_valid = 1'($urandom);
        b.len = 3'($urandom); b.syms = 28'($urandom);
        send_beat(b);
    endtask

    task automatic write_reg(logic idx, logic [6:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    // hold the sender until the block has drained
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // expression grammar: E -> T X, X -> + T X | eps, T -> a | ( E )
    task automatic gen_expr(int lvl);
        gen_term(lvl);
        repeat ($urandom_range(0, 2)) begin
            sentence = {sentence, CH_PLUS};
            gen_term(lvl);
        end
    endtask

    task automatic gen_term(int lvl);
        if (lvl > 0 && $urandom_range(0, 2) == 0) begin
            sentence = {sentence, CH_LP};
            gen_expr(lvl - 1);
            sentence = {sentence, CH_RP};
        end else begin
            sentence = {sentence, CH_A};
        end
    endtask

    task automatic load_grammar();
        load_rule(ROW_E, CH_A, 1, 2, pack4(CH_T, CH_X, 0, 0));
        load_rule(ROW_E, CH_LP, 1, 2, pack4(CH_T, CH_X, 0, 0));
        load_rule(ROW_X, CH_PLUS, 1, 3, pack4(CH_PLUS, CH_T, CH_X, 0));
        load_rule(ROW_X, CH_RP, 1, 0, 28'h0);
        load_rule(ROW_X, llp_pkg::END_MARK, 1, 0, 28'h0);
        load_rule(ROW_T, CH_A, 1, 1, pack4(CH_A, 0, 0, 0));
        load_rule(ROW_T, CH_LP, 1, 3, pack4(CH_LP, CH_E, CH_RP, 0));
        // self-feeding rule that grows the stack until it overflows
        load_rule(ROW_E, CH_O, 1, 4, pack4(CH_E, CH_E, CH_E, CH_E));
    endtask

    task automatic random_phase(int n_items);
        int sent;
        logic [4:0] row;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0: begin
                    do row = 5'($urandom); while (row == ROW_E || row == ROW_T || row == ROW_X);
                    load_rule(row, 7'($urandom), 1'($urandom), 3'($urandom), 28'($urandom));
                    sent++;
                end
                1: begin
                    send_token($urandom_range(0, 3) == 0 ? CH_O : 7'($urandom),
                               $urandom_range(0, 3) == 0);
                    sent++;
                end
                default: begin
                    sentence.delete();
                    gen_expr(2);
                    if ($urandom_range(0, 7) == 0)
                        sentence[$urandom_range(0, sentence.size() - 1)] = 7'($urandom);
                    foreach (sentence[i]) send_token(sentence[i], 1'b0);
                    send_token(7'($urandom), 1'b1);
                    sent += sentence.size() + 1;
                end
            endcase
        end
        wait_drained();
    endtask

    initial begin
        sb.clear();
        i_rst_n = 0;
        i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        i_in_valid = 0; i_mode = 0; i_lookahead = 0; i_is_end = 0;
        i_load_nonterminal = 0; i_entry_valid = 0; i_rhs_length = 0; i_rhs_symbols = 0;
        i_out_ready = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under reset settings
        send_token(CH_A, 1'b1);                       // end alone: missing entry
        load_grammar();
        load_rule(5'd30, CH_A, 1, 2, 28'hFFFFFFF);     // row out of range
        load_rule(5'd16, 7'd127, 1, 3'd7, 28'hFFFFFFF); // overlong rhs, saturated
        load_rule(5'd16, 7'd0, 0, 3'd4, 28'h0);        // clear
        send_token(CH_A, 0); send_token(CH_PLUS, 0); send_token(CH_A, 0);
        send_token(7'd0, 1);                          // accept
        send_token(CH_LP, 0); send_token(CH_A, 0); send_token(CH_PLUS, 0);
        send_token(7'd127, 1);                        // end with T on top: missing entry
        send_token(CH_A, 0); send_token(CH_A, 0);     // missing entry for X
        send_token(CH_O, 0);                          // overflow
        wait_drained();

        // receiver holds off while the sender keeps offering
        hold_req = 1;
        random_phase(35);

        write_reg(llp_pkg::CFG_LIMIT, 6'd1);
        send_token(CH_O, 0);                          // limit
        random_phase(30);

        write_reg(llp_pkg::CFG_START, llp_pkg::END_MARK);
        write_reg(llp_pkg::CFG_LIMIT, 6'd63);
        send_token(CH_A, 1); send_token(CH_A, 0);     // end marker on top
        random_phase(25);

        write_reg(llp_pkg::CFG_START, 7'd127);
        write_reg(llp_pkg::CFG_LIMIT, 6'd5);
        send_token(7'd127, 0); send_token(CH_A, 1);
        random_phase(25);

        write_reg(llp_pkg::CFG_START, 7'd0);
        send_token(7'd0, 0); send_token(7'd1, 0);
        random_phase(20);

        write_reg(llp_pkg::CFG_START, CH_E);
        write_reg(llp_pkg::CFG_LIMIT, 6'd63);
        idle_en = 0;
        random_phase(40);

        if (sb.errors == 0)
            $display("ll1_predictive_parser_unit_test: clean");
        else
            $display("ll1_predictive_parser_unit_test: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/llp_pkg.sv
rtl/core/llp_ram.sv
rtl/core/llp_front.sv
rtl/core/llp_back.sv
rtl/core/ll1_predictive_parser_unit.sv
sim/ll1_predictive_parser_unit_test.sv
